// ===== design/rqc_pkg.sv =====
// Shared request codes and control types for the ring queue with browse cursor.
package rqc_pkg;

    localparam int unsigned REQ_W = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQUEUE = 3'd0,
        REQ_HEAD    = 3'd1,
        REQ_NEXT    = 3'd2,
        REQ_TAIL    = 3'd3,
        REQ_DEQUEUE = 3'd4
    } req_t;

    // Per-transaction control from the pointer logic to the storage and result stage
    typedef struct packed {
        logic wr_en;   // write entry word at the write address
        logic rd_en;   // result carries the word read at the read address
        logic ok;      // request succeeded
    } ctrl_t;

endpackage

// ===== design/ring_queue_with_cursor_top.sv =====
// Top level of the ring queue with browse cursor: stream ports, entry storage, result register.
//
//  channel | direction | tdata fields, lowest bit first             | accepted when
//  s_      | in        | req_type[2:0], entry_in[ENTRY_WIDTH-1:0]   | s_tvalid && s_tready
//  m_      | out       | success[0], entry_out[ENTRY_WIDTH-1:0]     | m_tvalid && m_tready
//
// One request per cycle: the pointer compare, pointer step and storage access for a
// transaction all happen in the cycle it is accepted, and its result sits in the result
// register from the next cycle. The storage read port is the single path that sets this.
// s_tready stays high while the result register is empty or being drained this cycle,
// so a stalled m_ side holds one result and stops further input.
// Reset clears the three pointers and the result valid; storage is not cleared.
module ring_queue_with_cursor_top #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned ENTRY_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // req_type [2:0], entry_in [ENTRY_WIDTH+2:3], zero pad above
    input  logic [((rqc_pkg::REQ_W+ENTRY_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // success [0], entry_out [ENTRY_WIDTH:1], zero pad above
    output logic [((1+ENTRY_WIDTH+7)/8)*8-1:0]   m_tdata
);
    import rqc_pkg::*;

    localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int unsigned M_BYTES = (1 + ENTRY_WIDTH + 7) / 8;
    localparam int unsigned M_W     = M_BYTES * 8;

    logic                   accept;
    logic [REQ_W-1:0]       req_type;
    logic [ENTRY_WIDTH-1:0] entry_in;
    logic [PTR_W-1:0]       wr_addr, rd_addr;
    ctrl_t                  ctrl;

    logic [ENTRY_WIDTH-1:0] entry_mem [QUEUE_DEPTH];
    logic [ENTRY_WIDTH-1:0] rd_data_reg;
    logic                   ret_reg;
    logic                   ok_reg;
    logic                   m_valid_reg;
    logic [ENTRY_WIDTH-1:0] entry_out;

    // Take a new request whenever the result register is free or emptying now
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign req_type = s_tdata[REQ_W-1:0];
    assign entry_in = s_tdata[REQ_W +: ENTRY_WIDTH];

    rqc_ptr_ctrl #(
        .PTR_W (PTR_W)
    ) u_ptr_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .req_type (req_type),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .ctrl     (ctrl)
    );

    // Entry storage: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            entry_mem[wr_addr] <= entry_in;
        end
        if (accept) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    // Result flags; payload is held while the m_ side stalls
    always_ff @(posedge aclk) begin
        if (accept) begin
            ret_reg <= ctrl.rd_en;
            ok_reg  <= ctrl.ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Drop the read word for enqueue, failures and unknown requests
    assign entry_out = ret_reg ? rd_data_reg : '0;
    assign m_tvalid  = m_valid_reg;
    // Zero-extend to whole bytes
    assign m_tdata   = M_W'({entry_out, ok_reg});

endmodule

// ===== design/rqc_ptr_ctrl.sv =====
// Pointer registers, request decode and full/empty/end-of-browse checks.
module rqc_ptr_ctrl #(
    parameter int unsigned PTR_W = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      accept,
    input  logic [rqc_pkg::REQ_W-1:0] req_type,
    output logic [PTR_W-1:0]          wr_addr,
    output logic [PTR_W-1:0]          rd_addr,
    output rqc_pkg::ctrl_t            ctrl
);
    import rqc_pkg::*;

    logic [PTR_W-1:0] oldest_reg, oldest_next;
    logic [PTR_W-1:0] free_reg,   free_next;
    logic [PTR_W-1:0] browse_reg, browse_next;
    logic [PTR_W-1:0] free_succ, browse_succ, oldest_succ, tail_idx;
    logic             empty;

    assign free_succ   = free_reg + PTR_W'(1);
    assign browse_succ = browse_reg + PTR_W'(1);
    assign oldest_succ = oldest_reg + PTR_W'(1);
    assign tail_idx    = free_reg - PTR_W'(1);
    assign empty       = (oldest_reg == free_reg);
    assign wr_addr     = free_reg;

    always_comb begin
        oldest_next = oldest_reg;
        free_next   = free_reg;
        browse_next = browse_reg;
        rd_addr     = oldest_reg;
        ctrl        = '0;
        if (accept) begin
            case (req_t'(req_type))
                REQ_ENQUEUE: begin
                    if (free_succ != oldest_reg) begin
                        ctrl.wr_en = 1'b1;
                        ctrl.ok    = 1'b1;
                        free_next  = free_succ;
                    end
                end
                REQ_HEAD: begin
                    if (!empty) begin
                        ctrl.rd_en  = 1'b1;
                        ctrl.ok     = 1'b1;
                        browse_next = oldest_reg;
                    end
                end
                REQ_NEXT: begin
                    rd_addr = browse_succ;
                    if (browse_succ != free_reg) begin
                        ctrl.rd_en  = 1'b1;
                        ctrl.ok     = 1'b1;
                        browse_next = browse_succ;
                    end
                end
                REQ_TAIL: begin
                    rd_addr = tail_idx;
                    if (!empty) begin
                        ctrl.rd_en = 1'b1;
                        ctrl.ok    = 1'b1;
                    end
                end
                REQ_DEQUEUE: begin
                    if (!empty) begin
                        ctrl.rd_en  = 1'b1;
                        ctrl.ok     = 1'b1;
                        oldest_next = oldest_succ;
                    end
                end
                default: begin
                    ctrl = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg <= '0;
            free_reg   <= '0;
            browse_reg <= '0;
        end else begin
            oldest_reg <= oldest_next;
            free_reg   <= free_next;
            browse_reg <= browse_next;
        end
    end

endmodule

// ===== design/rqc_checker.sv =====
// Port-level checks on the ring queue top level, bound to it.
module rqc_checker #(
    parameter int unsigned ENTRY_WIDTH = 32
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [((rqc_pkg::REQ_W+ENTRY_WIDTH+7)/8)*8-1:0] s_tdata,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [((1+ENTRY_WIDTH+7)/8)*8-1:0]   m_tdata
);
    import rqc_pkg::*;

    logic             s_acc;
    logic [REQ_W-1:0] s_req;

    assign s_acc = s_tvalid && s_tready;
    assign s_req = s_tdata[REQ_W-1:0];

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[ENTRY_WIDTH:1] == '0)
        else $error("failed result carries an entry");

    a_enq_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_req == REQ_ENQUEUE |=> m_tvalid && m_tdata[ENTRY_WIDTH:1] == '0)
        else $error("enqueue result missing or non-zero");

    a_unknown_fails: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_req != REQ_ENQUEUE && s_req != REQ_HEAD && s_req != REQ_NEXT
            && s_req != REQ_TAIL && s_req != REQ_DEQUEUE |=> m_tvalid && !m_tdata[0])
        else $error("unknown request reported success");

endmodule

bind ring_queue_with_cursor_top rqc_checker #(
    .ENTRY_WIDTH (ENTRY_WIDTH)
) u_rqc_checker (.*);
